@@ rtl/core/i2cjtag_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cjtag_pkg
// Command codes, port register map and helpers for the serial-to-JTAG bridge.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cjtag_pkg;

  localparam int STORE_DEPTH_DEF = 32;
  localparam int MAX_SHIFT_BITS  = 8;
  localparam int PORT_REGS       = 15;

  // Command codes (seven-bit bus addresses)
  localparam logic [6:0] CMD_STORE      = 7'h10;
  localparam logic [6:0] CMD_TMS        = 7'h12;
  localparam logic [6:0] CMD_TMS_CNT    = 7'h13;
  localparam logic [6:0] CMD_CAP_HI     = 7'h14;
  localparam logic [6:0] CMD_CAP_HI_CNT = 7'h15;
  localparam logic [6:0] CMD_TDI_HI     = 7'h16;
  localparam logic [6:0] CMD_TDI_HI_CNT = 7'h17;
  localparam logic [6:0] CMD_CAP_LO     = 7'h18;
  localparam logic [6:0] CMD_CAP_LO_CNT = 7'h19;
  localparam logic [6:0] CMD_TDI_LO     = 7'h1A;
  localparam logic [6:0] CMD_TDI_LO_CNT = 7'h1B;
  localparam logic [6:0] CMD_PORT_FIRST = 7'h30;
  localparam logic [6:0] CMD_PIN_A      = 7'h33;
  localparam logic [6:0] CMD_DIR_B      = 7'h34;
  localparam logic [6:0] CMD_PIN_B      = 7'h37;
  localparam logic [6:0] CMD_PIN_C      = 7'h3B;
  localparam logic [6:0] CMD_PORT_MID   = 7'h3C;
  localparam logic [6:0] CMD_PORT_HI0   = 7'h3E;
  localparam logic [6:0] CMD_PORT_LAST  = 7'h3F;

  localparam logic [7:0] READ_DEFAULT   = 8'hA5;
  localparam logic [7:0] DIR_B_FORCE    = 8'hC0;
  localparam logic [7:0] PORT_3E_RESET  = 8'b1010_0000;

  // Shift kinds
  localparam logic [1:0] KIND_TMS = 2'd0;
  localparam logic [1:0] KIND_TDI = 2'd1;
  localparam logic [1:0] KIND_CAP = 2'd2;
  localparam logic [1:0] KIND_TDO = 2'd3;

  typedef struct packed {
    logic       hit;
    logic [3:0] slot;
  } port_sel_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       read_valid;
    logic       tdi_level;
    logic       tms_level;
    logic       jtag_cycle;
  } out_item_t;

  // Map a command address onto a port register slot.
  function automatic port_sel_t port_slot(input logic [6:0] addr);
    port_sel_t ps;
    ps.hit  = 1'b0;
    ps.slot = addr[3:0];
    if (addr >= CMD_PORT_FIRST && addr <= CMD_PORT_MID) begin
      ps.hit = 1'b1;
    end else if (addr == CMD_PORT_HI0 || addr == CMD_PORT_LAST) begin
      ps.hit  = 1'b1;
      ps.slot = addr[3:0] - 4'd1;
    end
    return ps;
  endfunction

  // Reset value of a port register: direction entries all ones, slot 13 PORT_3E_RESET, others zero.
  function automatic logic [7:0] port_reset_val(input logic [3:0] slot);
    logic [7:0] v;
    v = 8'h00;
    if (slot == 4'd0 || slot == 4'd4 || slot == 4'd8) begin
      v = 8'hFF;
    end else if (slot == 4'd13) begin
      v = PORT_3E_RESET;
    end
    return v;
  endfunction

  // Clamp a bit count to 1..MAX_SHIFT_BITS and return count minus one.
  function automatic logic [2:0] clamp_last(input logic [7:0] count);
    logic [2:0] r;
    if (count == 8'd0) begin
      r = 3'd0;
    end else if (count > 8'(MAX_SHIFT_BITS)) begin
      r = 3'(MAX_SHIFT_BITS - 1);
    end else begin
      r = 3'(count - 8'd1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/i2c_to_jtag_bridge_unit.sv @@
// ----------------------------------------------------------------------------
// i2c_to_jtag_bridge_unit
// Register-addressed bridge from serial-bus transfers to a JTAG TMS/TDI output stream.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one bus event per transfer: an address phase
//   (in_tuser = 0) that selects a command and, on a read, asks for one byte,
//   or a data byte written by the master (in_tuser = 1). The output channel
//   carries one transfer per test clock period (TMS/TDI levels), plus one
//   transfer holding a read answer when a read shifts nothing. out_tlast
//   marks the final result caused by an input transfer.
//   The shift sequencer drives one period per cycle through a single
//   bit-select and capture shift unit, as long as the output is not stalled.
//   One transfer is in work at a time; in_tready is low until it is done.
//   Reset (rst_n low, synchronous) clears the selected command, index, bit
//   count, capture byte, held TMS/TDI levels and the buffer valid bits, and
//   loads the port registers with their defaults.
//   When the receiver stalls, the output register holds its transfer and the
//   sequencer waits; no period is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_to_jtag_bridge_unit #(
  parameter int STORE_DEPTH = i2cjtag_pkg::STORE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [6:0] command_address, [7] read_not_write, [15:8] data_byte,
  // [23:16] tdo_levels, [31:24] port_pin_levels
  input  wire logic [31:0] in_tdata,
  // [0] operation
  input  wire logic [0:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] jtag_cycle, [1] tms_level, [2] tdi_level, [3] read_valid,
  // [11:4] read_byte, [15:12] zero
  output logic [15:0]      out_tdata,
  output logic             out_tlast
);

  localparam int IW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_RESP  = 2'd2;

  // Input fields
  logic       op;
  logic [6:0] in_addr;
  logic       in_rnw;
  logic [7:0] in_byte;
  logic [7:0] in_tdo;
  logic [7:0] in_pins;

  assign op      = in_tuser[0];
  assign in_addr = in_tdata[6:0];
  assign in_rnw  = in_tdata[7];
  assign in_byte = in_tdata[15:8];
  assign in_tdo  = in_tdata[23:16];
  assign in_pins = in_tdata[31:24];

  // Control and shift state
  logic [1:0]    state_r, state_nxt;
  logic [6:0]    sel_r, sel_nxt;
  logic [IW-1:0] idx_r, idx_nxt, idx_inc;
  logic [7:0]    bcnt_r, bcnt_nxt;
  logic [7:0]    cap_r, cap_nxt;
  logic          tms_held_r, tms_held_nxt;
  logic          tdi_held_r, tdi_held_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [7:0]    val_r, val_nxt;
  logic [7:0]    tdo_r, tdo_nxt;
  logic          tmsl_r, tmsl_nxt;
  logic [2:0]    k_r, k_nxt;
  logic [2:0]    nm1_r, nm1_nxt;
  logic [7:0]    acc_r, acc_nxt;
  logic          bit_r, bit_nxt;
  logic [7:0]    resp_r, resp_nxt;
  logic          resp_mem_r, resp_mem_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  i2cjtag_pkg::out_item_t out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;

  // Buffer memory and port registers
  logic [7:0]             mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] mem_vld_r;
  logic [7:0]             mem_rd_r;
  logic                   mem_rd_vld_r;
  logic                   mem_we;
  logic [IW-1:0]          mem_wa;
  logic [7:0]             mem_wd;

  logic [7:0]             port_r [i2cjtag_pkg::PORT_REGS];
  logic                   port_we;
  logic [3:0]             port_wa;
  logic [7:0]             port_wd;

  // Handshake helpers
  logic                   accept;
  logic                   out_free;
  logic                   shift_last;
  logic                   shift_tms;
  logic                   shift_tdi;
  logic [7:0]             shift_final;
  i2cjtag_pkg::port_sel_t ps_rd;
  i2cjtag_pkg::port_sel_t ps_wr;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign idx_inc = (idx_r == IW'(STORE_DEPTH - 1)) ? '0 : idx_r + IW'(1);

  assign ps_rd = i2cjtag_pkg::port_slot(in_addr);
  assign ps_wr = i2cjtag_pkg::port_slot(sel_r);

  // Shared shift unit: one test clock period per step.
  assign shift_last  = (k_r == nm1_r);
  assign shift_tms   = (kind_r == i2cjtag_pkg::KIND_TMS) ? val_r[k_r] :
                       (shift_last ? tmsl_r : 1'b0);
  assign shift_tdi   = (kind_r == i2cjtag_pkg::KIND_TDI ||
                        kind_r == i2cjtag_pkg::KIND_CAP) ? val_r[k_r] : tdi_held_r;
  // Capture takes one extra left shift after the last period.
  assign shift_final = {acc_r[5:0], bit_r, tdo_r[k_r]};

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    idx_nxt       = idx_r;
    bcnt_nxt      = bcnt_r;
    cap_nxt       = cap_r;
    tms_held_nxt  = tms_held_r;
    tdi_held_nxt  = tdi_held_r;
    kind_nxt      = kind_r;
    val_nxt       = val_r;
    tdo_nxt       = tdo_r;
    tmsl_nxt      = tmsl_r;
    k_nxt         = k_r;
    nm1_nxt       = nm1_r;
    acc_nxt       = acc_r;
    bit_nxt       = bit_r;
    resp_nxt      = resp_r;
    resp_mem_nxt  = resp_mem_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_wa        = idx_r;
    mem_wd        = in_byte;
    port_we       = 1'b0;
    port_wa       = ps_wr.slot;
    port_wd       = in_byte;

    // Drop the output transfer once taken.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (!op) begin
            // Address phase: select command, clear the index.
            sel_nxt = in_addr;
            idx_nxt = '0;
            if (in_rnw) begin
              resp_mem_nxt = 1'b0;
              state_nxt    = ST_RESP;
              if (in_addr == i2cjtag_pkg::CMD_STORE) begin
                // Buffer entry 0 is read, the index advances past it.
                resp_mem_nxt = 1'b1;
                idx_nxt      = IW'(1);
              end else if (in_addr inside {i2cjtag_pkg::CMD_CAP_HI,
                                           i2cjtag_pkg::CMD_CAP_HI_CNT,
                                           i2cjtag_pkg::CMD_CAP_LO,
                                           i2cjtag_pkg::CMD_CAP_LO_CNT}) begin
                resp_nxt = cap_r;
              end else if (in_addr inside {i2cjtag_pkg::CMD_TDI_HI,
                                           i2cjtag_pkg::CMD_TDI_HI_CNT,
                                           i2cjtag_pkg::CMD_TDI_LO,
                                           i2cjtag_pkg::CMD_TDI_LO_CNT}) begin
                // Fresh TDO capture: shift with TDI held, answer on last period.
                kind_nxt  = i2cjtag_pkg::KIND_TDO;
                val_nxt   = 8'h00;
                tdo_nxt   = in_tdo;
                tmsl_nxt  = (in_addr <= i2cjtag_pkg::CMD_TDI_HI_CNT);
                nm1_nxt   = in_addr[0] ? i2cjtag_pkg::clamp_last(bcnt_r) :
                                         3'(i2cjtag_pkg::MAX_SHIFT_BITS - 1);
                k_nxt     = 3'd0;
                acc_nxt   = 8'h00;
                bit_nxt   = 1'b0;
                state_nxt = ST_SHIFT;
              end else if (in_addr inside {i2cjtag_pkg::CMD_PIN_A,
                                           i2cjtag_pkg::CMD_PIN_B,
                                           i2cjtag_pkg::CMD_PIN_C}) begin
                resp_nxt = in_pins;
              end else if (ps_rd.hit) begin
                resp_nxt = port_r[ps_rd.slot];
              end else begin
                resp_nxt = i2cjtag_pkg::READ_DEFAULT;
              end
            end
          end else begin
            // Data byte written under the selected command.
            if (sel_r == i2cjtag_pkg::CMD_STORE) begin
              mem_we  = 1'b1;
              idx_nxt = idx_inc;
            end else if (sel_r inside {[i2cjtag_pkg::CMD_TMS :
                                        i2cjtag_pkg::CMD_TDI_LO_CNT]}) begin
              if (sel_r <= i2cjtag_pkg::CMD_TMS_CNT) begin
                kind_nxt = i2cjtag_pkg::KIND_TMS;
              end else if (sel_r <= i2cjtag_pkg::CMD_CAP_HI_CNT ||
                           sel_r == i2cjtag_pkg::CMD_CAP_LO ||
                           sel_r == i2cjtag_pkg::CMD_CAP_LO_CNT) begin
                kind_nxt = i2cjtag_pkg::KIND_CAP;
              end else begin
                kind_nxt = i2cjtag_pkg::KIND_TDI;
              end
              tmsl_nxt = (sel_r >= i2cjtag_pkg::CMD_CAP_HI &&
                          sel_r <= i2cjtag_pkg::CMD_TDI_HI_CNT);
              if (sel_r[0] && idx_r == '0) begin
                // Count-first byte: load the bit count, shift nothing.
                bcnt_nxt = in_byte;
                idx_nxt  = idx_inc;
              end else begin
                if (sel_r[0]) begin
                  idx_nxt = idx_inc;
                  nm1_nxt = i2cjtag_pkg::clamp_last(bcnt_r);
                end else begin
                  nm1_nxt = 3'(i2cjtag_pkg::MAX_SHIFT_BITS - 1);
                end
                val_nxt   = in_byte;
                tdo_nxt   = in_tdo;
                k_nxt     = 3'd0;
                acc_nxt   = cap_r;
                bit_nxt   = 1'b0;
                state_nxt = ST_SHIFT;
              end
            end else if (ps_wr.hit) begin
              port_we = 1'b1;
              if (sel_r inside {i2cjtag_pkg::CMD_PIN_A, i2cjtag_pkg::CMD_PIN_B,
                                i2cjtag_pkg::CMD_PIN_C}) begin
                // Pin address writes go to the latch two slots below.
                port_wa = ps_wr.slot - 4'd2;
              end
              if (sel_r == i2cjtag_pkg::CMD_DIR_B) begin
                port_wd = in_byte | i2cjtag_pkg::DIR_B_FORCE;
              end
            end
          end
        end
      end

      ST_SHIFT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.jtag_cycle  = 1'b1;
          out_data_nxt.tms_level   = shift_tms;
          out_data_nxt.tdi_level   = shift_tdi;
          out_data_nxt.read_valid  = 1'b0;
          out_data_nxt.read_byte   = 8'h00;
          out_last_nxt             = shift_last;
          tms_held_nxt             = shift_tms;
          tdi_held_nxt             = shift_tdi;
          acc_nxt                  = {acc_r[6:0], bit_r};
          bit_nxt                  = tdo_r[k_r];
          k_nxt                    = k_r + 3'd1;
          if (shift_last) begin
            if (kind_r == i2cjtag_pkg::KIND_TDO) begin
              out_data_nxt.read_valid = 1'b1;
              out_data_nxt.read_byte  = shift_final;
            end
            if (kind_r == i2cjtag_pkg::KIND_CAP) begin
              cap_nxt = shift_final;
            end
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.jtag_cycle  = 1'b0;
          out_data_nxt.tms_level   = tms_held_r;
          out_data_nxt.tdi_level   = tdi_held_r;
          out_data_nxt.read_valid  = 1'b1;
          out_data_nxt.read_byte   = resp_mem_r ? (mem_rd_vld_r ? mem_rd_r : 8'h00) :
                                                  resp_r;
          out_last_nxt             = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= 7'd0;
      idx_r       <= '0;
      bcnt_r      <= 8'd0;
      cap_r       <= 8'd0;
      tms_held_r  <= 1'b0;
      tdi_held_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mem_vld_r   <= '0;
      for (int i = 0; i < i2cjtag_pkg::PORT_REGS; i++) begin
        port_r[i] <= i2cjtag_pkg::port_reset_val(4'(i));
      end
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      idx_r       <= idx_nxt;
      bcnt_r      <= bcnt_nxt;
      cap_r       <= cap_nxt;
      tms_held_r  <= tms_held_nxt;
      tdi_held_r  <= tdi_held_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_we) begin
        mem_vld_r[mem_wa] <= 1'b1;
      end
      if (port_we) begin
        port_r[port_wa] <= port_wd;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    val_r        <= val_nxt;
    tdo_r        <= tdo_nxt;
    tmsl_r       <= tmsl_nxt;
    k_r          <= k_nxt;
    nm1_r        <= nm1_nxt;
    acc_r        <= acc_nxt;
    bit_r        <= bit_nxt;
    resp_r       <= resp_nxt;
    resp_mem_r   <= resp_mem_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Buffer memory: reads only ever hit entry 0, since an address transfer
  // clears the index before the read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_r     <= mem[0];
    mem_rd_vld_r <= mem_vld_r[0];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_data_r};
  assign out_tlast  = out_last_r;

  // Assertions
  a_read_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.read_valid) |-> out_last_r)
    else $error("read answer not on the final result");

  a_nonperiod_is_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.jtag_cycle) |-> out_data_r.read_valid)
    else $error("non-period result without a read answer");

  a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> (k_r <= nm1_r))
    else $error("shift step beyond the bit count");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IW'(STORE_DEPTH - 1))
    else $error("byte index out of range");

  a_shift_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT && out_free && shift_last) |=> (state_r == ST_IDLE))
    else $error("shift did not finish after its last period");

endmodule

`default_nettype wire

@@ tb/i2c_jtag_bridge_checker.sv @@
// ----------------------------------------------------------------------------
// i2c_jtag_bridge_checker
// Watches both streams of the bridge, predicts the JTAG periods and read
// answers of every accepted bus event and compares them in order.
// ----------------------------------------------------------------------------
module i2c_jtag_bridge_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tlast,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_DATA = 1'b1;

  typedef struct packed {
    logic       cyc;
    logic       tms;
    logic       tdi;
    logic       rv;
    logic [7:0] rb;
    logic       tlast;
  } jtag_result_t;

  jtag_result_t queued_jtag_results[$];
  jtag_result_t event_results[$];

  logic [6:0]  sel_cmd;
  int unsigned byte_idx;
  logic [7:0]  bit_cnt;
  logic [7:0]  capture;
  logic [7:0]  byte_store [i2cjtag_pkg::STORE_DEPTH_DEF];
  logic [7:0]  port_regs [i2cjtag_pkg::PORT_REGS];
  logic        tms_held;
  logic        tdi_held;

  function automatic int periods_for(input logic [7:0] cnt);
    if (cnt == 8'd0) return 1;
    if (cnt > 8'(i2cjtag_pkg::MAX_SHIFT_BITS)) return i2cjtag_pkg::MAX_SHIFT_BITS;
    return int'(cnt);
  endfunction

  function automatic int port_index(input logic [6:0] a);
    if (a >= i2cjtag_pkg::CMD_PORT_FIRST && a <= i2cjtag_pkg::CMD_PORT_MID)
      return int'(a - i2cjtag_pkg::CMD_PORT_FIRST);
    if (a == i2cjtag_pkg::CMD_PORT_HI0 || a == i2cjtag_pkg::CMD_PORT_LAST)
      return int'(a - i2cjtag_pkg::CMD_PORT_FIRST) - 1;
    return -1;
  endfunction

  function automatic logic is_pin_cmd(input logic [6:0] a);
    return a == i2cjtag_pkg::CMD_PIN_A || a == i2cjtag_pkg::CMD_PIN_B ||
           a == i2cjtag_pkg::CMD_PIN_C;
  endfunction

  task automatic reset_model();
    int i;
    sel_cmd  = '0;
    byte_idx = 0;
    bit_cnt  = '0;
    capture  = '0;
    tms_held = 1'b0;
    tdi_held = 1'b0;
    for (i = 0; i < i2cjtag_pkg::STORE_DEPTH_DEF; i++) byte_store[i] = 8'h00;
    for (i = 0; i < i2cjtag_pkg::PORT_REGS; i++) port_regs[i] = 8'h00;
    // direction registers sit at every fourth slot of the low port block
    for (i = 0; i < 12; i += 4) port_regs[i] = 8'hFF;
    port_regs[port_index(i2cjtag_pkg::CMD_PORT_HI0)] = i2cjtag_pkg::PORT_3E_RESET;
    queued_jtag_results.delete();
  endtask

  task automatic step_index();
    byte_idx = (byte_idx + 1) % i2cjtag_pkg::STORE_DEPTH_DEF;
  endtask

  task automatic add_result(input logic cyc, input logic tms, input logic tdi,
                            input logic rv, input logic [7:0] rb);
    jtag_result_t r;
    r.cyc   = cyc;
    r.tms   = tms;
    r.tdi   = tdi;
    r.rv    = rv;
    r.rb    = rb;
    r.tlast = 1'b0;
    event_results.push_back(r);
  endtask

  // One result per test clock period. The capture byte shifts in a zero
  // first, then the TDO sample of each period, one period late.
  task automatic run_periods(input logic [1:0] kind, input logic [7:0] val, input int n,
                             input logic tms_last, input logic [7:0] tdo,
                             inout logic [7:0] acc);
    logic t;
    logic d;
    logic smp;
    int   k;
    t   = tms_held;
    d   = tdi_held;
    smp = 1'b0;
    for (k = 0; k < n; k++) begin
      if (kind == i2cjtag_pkg::KIND_TMS) t = val[k];
      else t = (k == n - 1) ? tms_last : 1'b0;
      if (kind == i2cjtag_pkg::KIND_TDI || kind == i2cjtag_pkg::KIND_CAP) d = val[k];
      acc = {acc[6:0], smp};
      smp = tdo[k];
      add_result(1'b1, t, d, 1'b0, 8'h00);
    end
    acc = {acc[6:0], smp};
    tms_held = t;
    tdi_held = d;
  endtask

  task automatic write_data(input logic [7:0] data, input logic [7:0] tdo);
    logic [1:0] kind;
    logic [7:0] acc;
    logic [7:0] value;
    logic       shifting;
    int         n;
    int         slot;
    value    = data;
    shifting = 1'b0;
    n        = i2cjtag_pkg::MAX_SHIFT_BITS;
    if (sel_cmd == i2cjtag_pkg::CMD_STORE) begin
      byte_store[byte_idx] = value;
      step_index();
    end else if (sel_cmd >= i2cjtag_pkg::CMD_TMS &&
                 sel_cmd <= i2cjtag_pkg::CMD_TDI_LO_CNT) begin
      if (sel_cmd <= i2cjtag_pkg::CMD_TMS_CNT) kind = i2cjtag_pkg::KIND_TMS;
      else if (sel_cmd inside {i2cjtag_pkg::CMD_CAP_HI, i2cjtag_pkg::CMD_CAP_HI_CNT,
                               i2cjtag_pkg::CMD_CAP_LO, i2cjtag_pkg::CMD_CAP_LO_CNT})
        kind = i2cjtag_pkg::KIND_CAP;
      else kind = i2cjtag_pkg::KIND_TDI;
      shifting = 1'b1;
      if (sel_cmd[0]) begin
        // count-first forms: a byte at index zero loads the count, shifts nothing
        if (byte_idx == 0) begin
          bit_cnt  = value;
          shifting = 1'b0;
        end else begin
          n = periods_for(bit_cnt);
        end
        step_index();
      end
      if (shifting) begin
        acc = capture;
        run_periods(kind, value, n,
                    sel_cmd >= i2cjtag_pkg::CMD_CAP_HI &&
                    sel_cmd <= i2cjtag_pkg::CMD_TDI_HI_CNT,
                    tdo, acc);
        if (kind == i2cjtag_pkg::KIND_CAP) capture = acc;
      end
    end else begin
      slot = port_index(sel_cmd);
      if (slot >= 0) begin
        if (sel_cmd == i2cjtag_pkg::CMD_DIR_B) value |= i2cjtag_pkg::DIR_B_FORCE;
        // pin addresses write the latch two slots below
        if (is_pin_cmd(sel_cmd)) slot -= 2;
        port_regs[slot] = value;
      end
    end
  endtask

  task automatic read_address(input logic [6:0] a, input logic [7:0] tdo,
                              input logic [7:0] pins);
    logic [7:0]   answer;
    logic [7:0]   acc;
    int           n;
    jtag_result_t r;
    answer = i2cjtag_pkg::READ_DEFAULT;
    if (a inside {i2cjtag_pkg::CMD_TDI_HI, i2cjtag_pkg::CMD_TDI_HI_CNT,
                  i2cjtag_pkg::CMD_TDI_LO, i2cjtag_pkg::CMD_TDI_LO_CNT}) begin
      // fresh TDO capture: the answer rides on the last period
      n   = a[0] ? periods_for(bit_cnt) : i2cjtag_pkg::MAX_SHIFT_BITS;
      acc = 8'h00;
      run_periods(i2cjtag_pkg::KIND_TDO, 8'h00, n, a <= i2cjtag_pkg::CMD_TDI_HI_CNT,
                  tdo, acc);
      r    = event_results.pop_back();
      r.rv = 1'b1;
      r.rb = acc;
      event_results.push_back(r);
    end else begin
      if (a == i2cjtag_pkg::CMD_STORE) begin
        answer = byte_store[byte_idx];
        step_index();
      end else if (a inside {i2cjtag_pkg::CMD_CAP_HI, i2cjtag_pkg::CMD_CAP_HI_CNT,
                             i2cjtag_pkg::CMD_CAP_LO, i2cjtag_pkg::CMD_CAP_LO_CNT}) begin
        answer = capture;
      end else if (is_pin_cmd(a)) begin
        answer = pins;
      end else if (port_index(a) >= 0) begin
        answer = port_regs[port_index(a)];
      end
      add_result(1'b0, tms_held, tdi_held, 1'b1, answer);
    end
  endtask

  task automatic bus_event(input logic op, input logic [6:0] a, input logic rnw,
                           input logic [7:0] data, input logic [7:0] tdo,
                           input logic [7:0] pins);
    jtag_result_t r;
    event_results.delete();
    if (op == OP_DATA) begin
      write_data(data, tdo);
    end else begin
      sel_cmd  = a;
      byte_idx = 0;
      if (rnw) read_address(a, tdo, pins);
    end
    if (event_results.size() > 0) begin
      r       = event_results.pop_back();
      r.tlast = 1'b1;
      event_results.push_back(r);
    end
    foreach (event_results[i]) queued_jtag_results.push_back(event_results[i]);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    jtag_result_t want_r;
    if (!rst_n) begin
      reset_model();
    end else begin
      if (out_tvalid && out_tready) begin
        if (queued_jtag_results.size() == 0) begin
          $display("%0t ns: result 0x%0h with nothing expected, expected none, actual 0x%0h",
                   $time, out_tdata, out_tdata);
          mismatches++;
        end else begin
          want_r = queued_jtag_results.pop_front();
          check_field("jtag_cycle", 8'(want_r.cyc), 8'(out_tdata[0]));
          check_field("tms_level", 8'(want_r.tms), 8'(out_tdata[1]));
          check_field("tdi_level", 8'(want_r.tdi), 8'(out_tdata[2]));
          check_field("read_valid", 8'(want_r.rv), 8'(out_tdata[3]));
          check_field("read_byte", want_r.rb, out_tdata[11:4]);
          check_field("tdata padding", 8'h00, 8'(out_tdata[15:12]));
          check_field("tlast", 8'(want_r.tlast), 8'(out_tlast));
        end
      end
      if (in_tvalid && in_tready) begin
        bus_event(in_tuser[0], in_tdata[6:0], in_tdata[7], in_tdata[15:8],
                  in_tdata[23:16], in_tdata[31:24]);
      end
    end
    outstanding <= queued_jtag_results.size();
  end

endmodule

@@ tb/tb_i2c_to_jtag_bridge_unit.sv @@
// ----------------------------------------------------------------------------
// tb_i2c_to_jtag_bridge_unit
// Drives bus events into the serial-to-JTAG bridge: a directed pass over the
// command set and its corner cases, then random command sequences with random
// idling on both streams, a stretch with no idling and one long receiver
// hold-off. A checker beside the block predicts and compares every transfer.
// ----------------------------------------------------------------------------
module tb_i2c_to_jtag_bridge_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_ADDR = 1'b0;
  localparam logic OP_DATA = 1'b1;

  // 0x3D sits inside the port block but maps to nothing
  localparam logic [6:0] CMD_UNMAPPED = i2cjtag_pkg::CMD_PORT_MID + 7'd1;
  // latch register that pin writes of port A land in
  localparam logic [6:0] CMD_LATCH_A  = i2cjtag_pkg::CMD_PIN_A - 7'd2;

  localparam int DIRECTED_ITEMS = 99;
  localparam int TOTAL_ITEMS    = 130;
  localparam int IDLE_PCT       = 36;
  localparam int HOLD_CYCLES    = 300;
  // worst quiet run: the hold-off plus a full byte shift and gaps
  localparam int STALL_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 20;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;

  int   mismatches;
  int   outstanding;
  int   quiet_cycles = 0;
  logic tx_steady    = 1'b0;
  logic rx_steady    = 1'b0;
  logic hold_req     = 1'b0;

  i2c_to_jtag_bridge_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  i2c_jtag_bridge_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: stall at random, never while steady; on request hold off for a
  // long stretch so the output register fills and the block stops taking input.
  initial begin : receiver
    logic hold_done;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_tready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: end the run when no transfer moves on either stream for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offer one bus event; called and returning at a falling edge. Idle gaps
  // drop tvalid first; the transfer is taken at the rising edge with tready.
  task automatic offer(input logic op, input logic [6:0] addr, input logic rnw,
                       input logic [7:0] data, input logic [7:0] tdo,
                       input logic [7:0] pins);
    while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tuser  <= op;
    in_tdata  <= {pins, tdo, data, rnw, addr};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic addr_read(input logic [6:0] cmd, input logic [7:0] tdo,
                           input logic [7:0] pins);
    offer(OP_ADDR, cmd, 1'b1, 8'($urandom), tdo, pins);
  endtask

  task automatic addr_write(input logic [6:0] cmd);
    offer(OP_ADDR, cmd, 1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // The read flag is random here: data items ignore it.
  task automatic data_write(input logic [7:0] data, input logic [7:0] tdo);
    offer(OP_DATA, 7'($urandom), 1'($urandom), data, tdo, 8'($urandom));
  endtask

  // Bias bytes toward extremes and small shift counts.
  function automatic logic [7:0] data_value();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'($urandom_range(9));
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int         sent;
    int         burst;
    int         k;
    logic [6:0] cmd;
    logic       hold_used;

    sent      = 0;
    hold_used = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset values, buffer, every shift family and port quirks.
    addr_read(i2cjtag_pkg::CMD_PORT_HI0, 8'h00, 8'h00);
    addr_read(i2cjtag_pkg::CMD_STORE, 8'hFF, 8'hFF);   // never-written byte reads zero
    addr_write(i2cjtag_pkg::CMD_STORE);
    data_write(8'hFF, 8'h00);
    data_write(8'h00, 8'hFF);
    addr_read(i2cjtag_pkg::CMD_STORE, 8'h00, 8'h00);
    addr_write(i2cjtag_pkg::CMD_TMS);
    data_write(8'hA5, 8'h00);
    addr_write(i2cjtag_pkg::CMD_CAP_HI);
    data_write(8'h3C, 8'hFF);
    addr_read(i2cjtag_pkg::CMD_CAP_HI, 8'h00, 8'h00);
    addr_write(i2cjtag_pkg::CMD_TDI_HI_CNT);
    data_write(8'h00, 8'h00);                    // count byte of zero: the next byte shifts one period
    data_write(8'hFF, 8'hFF);
    addr_write(i2cjtag_pkg::CMD_CAP_LO_CNT);
    data_write(8'hFF, 8'h00);                    // oversized count stops at eight
    data_write(8'h55, 8'hAA);
    addr_read(i2cjtag_pkg::CMD_TDI_LO, 8'hAA, 8'h00);
    addr_write(i2cjtag_pkg::CMD_DIR_B);
    data_write(8'h00, 8'h00);                    // top two direction bits stick
    addr_read(i2cjtag_pkg::CMD_DIR_B, 8'h00, 8'h00);
    addr_write(i2cjtag_pkg::CMD_PIN_A);
    data_write(8'h5A, 8'h00);
    addr_read(CMD_LATCH_A, 8'h00, 8'h00);
    addr_read(i2cjtag_pkg::CMD_PIN_A, 8'h00, 8'hFF);
    addr_write(CMD_UNMAPPED);
    data_write(8'h77, 8'h00);                    // unmapped write: no result
    addr_read('1, 8'hFF, 8'h00);
    addr_read('0, 8'h00, 8'hFF);

    // Wrap the byte index in the buffer and in a count-first shift.
    addr_write(i2cjtag_pkg::CMD_STORE);
    repeat (33) data_write(data_value(), 8'($urandom));
    addr_read(i2cjtag_pkg::CMD_STORE, 8'($urandom), 8'($urandom));
    addr_write(i2cjtag_pkg::CMD_TMS_CNT);
    repeat (34) data_write(data_value(), 8'($urandom));
    sent = DIRECTED_ITEMS;

    // Random command sequences, with some noise.
    while (sent < TOTAL_ITEMS) begin
      if (!hold_used) begin
        hold_req  = 1'b1;
        hold_used = 1'b1;
      end
      tx_steady = (sent >= 108 && sent < 124);
      rx_steady = tx_steady;
      if ($urandom_range(99) < 75) begin
        case ($urandom_range(4))
          0:       cmd = i2cjtag_pkg::CMD_STORE;
          1, 2:    cmd = 7'($urandom_range(i2cjtag_pkg::CMD_TMS,
                                           i2cjtag_pkg::CMD_TDI_LO_CNT));
          3:       cmd = 7'($urandom_range(i2cjtag_pkg::CMD_PORT_FIRST,
                                           i2cjtag_pkg::CMD_PORT_LAST));
          default: cmd = $urandom_range(1) ? i2cjtag_pkg::CMD_PIN_B :
                                             i2cjtag_pkg::CMD_PIN_C;
        endcase
        if ($urandom_range(3) == 0) begin
          addr_read(cmd, 8'($urandom), 8'($urandom));
          sent++;
        end else begin
          burst = $urandom_range(1, 6);
          addr_write(cmd);
          for (k = 0; k < burst; k++) data_write(data_value(), 8'($urandom));
          sent += burst + 1;
        end
      end else begin
        offer(1'($urandom), 7'($urandom), 1'($urandom), data_value(),
              8'($urandom), 8'($urandom));
        sent++;
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    in_tvalid <= 1'b0;

    // Drain: every predicted result must arrive; the watchdog covers a hang.
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
